// ----- sv/sobel_edge_threshold_defines.svh -----
// assertion macros for the sobel edge threshold block
`ifndef SOBEL_EDGE_THRESHOLD_DEFINES_SVH
`define SOBEL_EDGE_THRESHOLD_DEFINES_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define SET_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sobel edge threshold: same-cycle check failed");

// antecedent holds in a cycle, consequent holds in the next cycle
`define SET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sobel edge threshold: next-cycle check failed");

`endif

// ----- sv/sobel_pkg.sv -----
// types, constants and register indexes of the sobel edge threshold block
package sobel_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int MAX_HEIGHT        = 4096;
    localparam int MIN_DIM           = 3;

    localparam int DIM_W      = 14;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int OUT_COL_W  = 10;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [10:0] WIDTH_RESET     = 11'd640;
    localparam logic [12:0] HEIGHT_RESET    = 13'd480;
    localparam logic [10:0] THRESHOLD_RESET = 11'd200;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    // floor(x/3) for x up to 765 as (x*683) >> 11
    localparam int DIV3_RECIP = 683;
    localparam int DIV3_SHIFT = 11;

    localparam logic [7:0] LEVEL_EDGE    = 8'd0;
    localparam logic [7:0] LEVEL_NO_EDGE = 8'd255;

    typedef logic [7:0] pixel_t;

    typedef struct packed {
        logic [OUT_COL_W-1:0] center_column;
        logic [ROW_W-1:0]     center_row;
        logic                 frame_last;
    } item_meta_t;

endpackage

// ----- sv/sobel_edge_threshold.sv -----
// sobel edge threshold top level: line store, 3x3 window, gradient pipeline
// One pixel is taken per clock while the result is not stalled, and each pixel's result
// passes through the line store read and the four register stages behind it: window
// shift, absolute gradients, squares and threshold compare. The single line store memory is
// read when a pixel is taken and written back with the shifted line data at the next step.
// Both line rows share one memory entry per column and no clearing pass is run; entries are
// read before write only on the first two rows of the first frame, whose values never reach
// a result, or after the width grows mid-frame. Border pixels give no result, and a stalled
// result holds the whole pipeline.
`include "sobel_edge_threshold_defines.svh"

module sobel_edge_threshold #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_write,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_red,
    input  logic [7:0]                       s_green,
    input  logic [7:0]                       s_blue,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_edge_level,
    output logic [9:0]                       m_center_column,
    output logic [11:0]                      m_center_row,
    output logic                             m_frame_last
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW = sobel_pkg::DIM_W;
    localparam int HW = sobel_pkg::HEIGHT_W;
    localparam int RW = sobel_pkg::ROW_W;
    localparam logic [DW-1:0] W_MAX = DW'(MAX_WIDTH);
    localparam logic [DW-1:0] W_MIN = DW'(sobel_pkg::MIN_DIM);
    localparam logic [HW-1:0] H_MAX = HW'(sobel_pkg::MAX_HEIGHT);
    localparam logic [HW-1:0] H_MIN = HW'(sobel_pkg::MIN_DIM);

    // configuration
    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [10:0] edge_threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg    <= sobel_pkg::WIDTH_RESET;
            image_height_reg   <= sobel_pkg::HEIGHT_RESET;
            edge_threshold_reg <= sobel_pkg::THRESHOLD_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                sobel_pkg::REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[10:0];
                sobel_pkg::REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data[12:0];
                sobel_pkg::REG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // handshake
    logic advance;
    logic accept;
    logic m_valid_reg;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    // geometry and counters
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic [DW-1:0] w_raw, w_lim, col_ext, col_inc;
    logic [HW-1:0] h_lim, row_ext, row_inc;
    logic          in_produce;
    sobel_pkg::item_meta_t in_meta;

    always_comb begin
        w_raw = DW'(image_width_reg);
        if (w_raw < W_MIN) begin
            w_lim = W_MIN;
        end else if (w_raw > W_MAX) begin
            w_lim = W_MAX;
        end else begin
            w_lim = w_raw;
        end
        if (image_height_reg < H_MIN) begin
            h_lim = H_MIN;
        end else if (image_height_reg > H_MAX) begin
            h_lim = H_MAX;
        end else begin
            h_lim = image_height_reg;
        end

        col_ext = DW'(col_count_reg);
        col_inc = col_ext + DW'(1);
        row_ext = HW'(row_count_reg);
        row_inc = row_ext + HW'(1);

        if (col_inc >= w_lim) begin
            col_count_next = '0;
            row_count_next = (row_inc >= h_lim) ? '0 : row_inc[RW-1:0];
        end else begin
            col_count_next = col_inc[CW-1:0];
            row_count_next = (row_ext >= h_lim) ? '0 : row_count_reg;
        end

        in_produce = (col_ext >= DW'(2)) && (row_count_reg >= RW'(2));
        in_meta.center_column = sobel_pkg::OUT_COL_W'(col_ext - DW'(1));
        in_meta.center_row    = row_count_reg - RW'(1);
        in_meta.frame_last    = (col_ext == w_lim - DW'(1)) && (row_ext == h_lim - HW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (accept) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // gray conversion
    logic [9:0]       rgb_sum;
    logic [19:0]      gray_prod;
    sobel_pkg::pixel_t in_gray;

    always_comb begin
        rgb_sum   = 10'(s_red) + 10'(s_green) + 10'(s_blue);
        gray_prod = 20'(rgb_sum) * 20'(sobel_pkg::DIV3_RECIP);
        in_gray   = 8'(gray_prod >> sobel_pkg::DIV3_SHIFT);
    end

    // line store: {older, newer} per column
    logic [15:0] line_mem [MAX_WIDTH];
    logic [15:0] line_rdata_reg;

    logic                  s1_valid_reg;
    logic                  s1_produce_reg;
    logic [CW-1:0]         s1_addr_reg;
    sobel_pkg::pixel_t     s1_gray_reg;
    sobel_pkg::item_meta_t s1_meta_reg;

    sobel_pkg::pixel_t line_top, line_mid;
    logic              line_wr;

    assign line_top = line_rdata_reg[15:8];
    assign line_mid = line_rdata_reg[7:0];
    assign line_wr  = s1_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (accept) begin
            line_rdata_reg <= line_mem[col_count_reg];
        end
        if (line_wr) begin
            line_mem[s1_addr_reg] <= {line_mid, s1_gray_reg};
        end
    end

    // window, [row*3+col], col 2 newest
    sobel_pkg::pixel_t window_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                window_reg[i] <= '0;
            end
        end else if (line_wr) begin
            for (int k = 0; k < 3; k++) begin
                window_reg[k*3]   <= window_reg[k*3+1];
                window_reg[k*3+1] <= window_reg[k*3+2];
            end
            window_reg[2] <= line_top;
            window_reg[5] <= line_mid;
            window_reg[8] <= s1_gray_reg;
        end
    end

    // gradients
    logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [10:0] gx, gy;
    logic [9:0]         ax, ay;

    always_comb begin
        gx_pos = 10'(window_reg[2]) + {1'b0, window_reg[5], 1'b0} + 10'(window_reg[8]);
        gx_neg = 10'(window_reg[0]) + {1'b0, window_reg[3], 1'b0} + 10'(window_reg[6]);
        gy_pos = 10'(window_reg[0]) + {1'b0, window_reg[1], 1'b0} + 10'(window_reg[2]);
        gy_neg = 10'(window_reg[6]) + {1'b0, window_reg[7], 1'b0} + 10'(window_reg[8]);
        gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
        ax = gx[10] ? 10'(-gx) : 10'(gx);
        ay = gy[10] ? 10'(-gy) : 10'(gy);
    end

    logic                  s2_valid_reg, s3_valid_reg, s4_valid_reg;
    sobel_pkg::item_meta_t s2_meta_reg, s3_meta_reg, s4_meta_reg;
    logic [9:0]            s3_ax_reg, s3_ay_reg;
    logic [19:0]           s4_sqx_reg, s4_sqy_reg;
    logic [21:0]           s4_t2_reg;
    logic [20:0]           mag2;

    assign mag2 = 21'(s4_sqx_reg) + 21'(s4_sqy_reg);

    sobel_pkg::pixel_t     m_level_reg;
    sobel_pkg::item_meta_t m_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg && s1_produce_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_produce_reg <= in_produce;
            s1_addr_reg    <= col_count_reg;
            s1_gray_reg    <= in_gray;
            s1_meta_reg    <= in_meta;
        end
        if (advance) begin
            s2_meta_reg <= s1_meta_reg;
            s3_meta_reg <= s2_meta_reg;
            s3_ax_reg   <= ax;
            s3_ay_reg   <= ay;
            s4_meta_reg <= s3_meta_reg;
            s4_sqx_reg  <= 20'(s3_ax_reg) * 20'(s3_ax_reg);
            s4_sqy_reg  <= 20'(s3_ay_reg) * 20'(s3_ay_reg);
            s4_t2_reg   <= 22'(edge_threshold_reg) * 22'(edge_threshold_reg);
            m_meta_reg  <= s4_meta_reg;
            m_level_reg <= (22'(mag2) > s4_t2_reg) ? sobel_pkg::LEVEL_EDGE
                                                   : sobel_pkg::LEVEL_NO_EDGE;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_edge_level    = m_level_reg;
    assign m_center_column = m_meta_reg.center_column;
    assign m_center_row    = m_meta_reg.center_row;
    assign m_frame_last    = m_meta_reg.frame_last;

    // checks
    `SET_ASSERT_SAME(a_line_rw_apart, aclk, aresetn, line_wr && accept, col_count_reg != s1_addr_reg)
    `SET_ASSERT_NEXT(a_s1_holds, aclk, aresetn, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_addr_reg))
    `SET_ASSERT_SAME(a_row_interior, aclk, aresetn, m_valid_reg, m_center_row != 12'd0)

endmodule

// ----- tb/edge_map_checker.sv -----
// edge map checker: predicts each thresholded sobel result and compares the result channel
`timescale 1ns / 1ps

module edge_map_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_write,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [7:0]                       s_red,
    input  logic [7:0]                       s_green,
    input  logic [7:0]                       s_blue,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [7:0]                       m_edge_level,
    input  logic [9:0]                       m_center_column,
    input  logic [11:0]                      m_center_row,
    input  logic                             m_frame_last,
    output int                               mismatch_count,
    output int                               outstanding_edges
);
    import sobel_pkg::*;

    typedef struct packed {
        pixel_t     level;
        item_meta_t meta;
    } edge_result_t;

    logic [10:0]          width_reg;
    logic [HEIGHT_W-1:0]  height_reg;
    logic [10:0]          thresh_reg;
    pixel_t               older_row [MAX_WIDTH_DEFAULT];
    pixel_t               newer_row [MAX_WIDTH_DEFAULT];
    pixel_t               win [9];
    logic [OUT_COL_W-1:0] col_pos;
    logic [ROW_W-1:0]     row_pos;
    edge_result_t         expected_edges [$];
    edge_result_t         want;
    int                   fail_tally = 0;

    task automatic predict_edge_pixel(input pixel_t r, input pixel_t g, input pixel_t b);
        int                 w;
        int                 h;
        logic [9:0]         sum;
        pixel_t             gray;
        pixel_t             top;
        pixel_t             mid;
        logic signed [11:0] gx;
        logic signed [11:0] gy;
        logic [21:0]        mag2;
        logic [21:0]        t2;
        bit                 blind;
        edge_result_t       res;
        w = (width_reg < MIN_DIM) ? MIN_DIM :
            (width_reg > MAX_WIDTH_DEFAULT) ? MAX_WIDTH_DEFAULT : int'(width_reg);
        h = (height_reg < MIN_DIM) ? MIN_DIM :
            (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        sum  = 10'(r) + 10'(g) + 10'(b);
        gray = pixel_t'(sum / 10'd3);
        top  = older_row[col_pos];
        mid  = newer_row[col_pos];
        older_row[col_pos] = mid;
        newer_row[col_pos] = gray;
        for (int k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = gray;
        if (col_pos >= 2 && row_pos >= 2) begin
            blind = 1'b0;
            for (int k = 0; k < 9; k++) begin
                if ($isunknown(win[k])) begin
                    blind = 1'b1;
                end
            end
            gx = 12'(int'(win[2]) + 2 * int'(win[5]) + int'(win[8])
                   - int'(win[0]) - 2 * int'(win[3]) - int'(win[6]));
            gy = 12'(int'(win[0]) + 2 * int'(win[1]) + int'(win[2])
                   - int'(win[6]) - 2 * int'(win[7]) - int'(win[8]));
            mag2 = 22'(int'(gx) * int'(gx) + int'(gy) * int'(gy));
            t2   = 22'(thresh_reg) * 22'(thresh_reg);
            res.level              = (mag2 > t2) ? LEVEL_EDGE : LEVEL_NO_EDGE;
            // window holds a never-written line store entry
            if (blind) begin
                res.level = 'x;
            end
            res.meta.center_column = col_pos - 1'b1;
            res.meta.center_row    = row_pos - 1'b1;
            res.meta.frame_last    = (int'(col_pos) == w - 1) && (int'(row_pos) == h - 1);
            expected_edges.push_back(res);
        end
        // counters past a shrunken bound wrap at the end of the step
        if (int'(col_pos) + 1 >= w) begin
            col_pos = '0;
            row_pos = (int'(row_pos) + 1 >= h) ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
            if (int'(row_pos) >= h) begin
                row_pos = '0;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            thresh_reg = THRESHOLD_RESET;
            col_pos    = '0;
            row_pos    = '0;
            for (int k = 0; k < 9; k++) begin
                win[k] = '0;
            end
            expected_edges.delete();
            outstanding_edges <= 0;
            mismatch_count    <= fail_tally;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH: begin
                        width_reg = cfg_data[10:0];
                    end
                    REG_IMAGE_HEIGHT: begin
                        height_reg = cfg_data[HEIGHT_W-1:0];
                    end
                    REG_EDGE_THRESHOLD: begin
                        thresh_reg = cfg_data[10:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                predict_edge_pixel(s_red, s_green, s_blue);
            end
            if (m_valid && m_ready) begin
                if (expected_edges.size() == 0) begin
                    fail_tally++;
                    $display("%0t: unexpected transfer: level %0d column %0d row %0d last %0d",
                             $time, m_edge_level, m_center_column, m_center_row,
                             m_frame_last);
                end else begin
                    want = expected_edges.pop_front();
                    if (!$isunknown(want.level) && m_edge_level !== want.level) begin
                        fail_tally++;
                        $display("%0t: edge_level expected %0d got %0d",
                                 $time, want.level, m_edge_level);
                    end
                    if (m_center_column !== want.meta.center_column) begin
                        fail_tally++;
                        $display("%0t: center_column expected %0d got %0d",
                                 $time, want.meta.center_column, m_center_column);
                    end
                    if (m_center_row !== want.meta.center_row) begin
                        fail_tally++;
                        $display("%0t: center_row expected %0d got %0d",
                                 $time, want.meta.center_row, m_center_row);
                    end
                    if (m_frame_last !== want.meta.frame_last) begin
                        fail_tally++;
                        $display("%0t: frame_last expected %0d got %0d",
                                 $time, want.meta.frame_last, m_frame_last);
                    end
                end
            end
            outstanding_edges <= expected_edges.size();
            mismatch_count    <= fail_tally;
        end
    end

endmodule

// ----- tb/sobel_edge_threshold_test.sv -----
// top of the sobel edge threshold testbench: clock, reset, pixel and register stimulus, verdict
`timescale 1ns / 1ps

module sobel_edge_threshold_test;
    import sobel_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_PIXELS = 1850;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum {TEX_NOISE, TEX_SMOOTH, TEX_BILEVEL} texture_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    pixel_t                s_red;
    pixel_t                s_green;
    pixel_t                s_blue;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_edge_level;
    logic [OUT_COL_W-1:0]  m_center_column;
    logic [ROW_W-1:0]      m_center_row;
    logic                  m_frame_last;
    int                    mismatch_count;
    int                    outstanding_edges;
    int                    clock_count = 0;
    int                    stall_left = 0;
    bit                    stall_on = 1'b0;
    bit                    gap_on = 1'b0;
    texture_t              texture = TEX_NOISE;
    int                    level = 0;

    always #5 aclk = ~aclk;

    sobel_edge_threshold dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_edge_level    (m_edge_level),
        .m_center_column (m_center_column),
        .m_center_row    (m_center_row),
        .m_frame_last    (m_frame_last)
    );

    edge_map_checker edge_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_red             (s_red),
        .s_green           (s_green),
        .s_blue            (s_blue),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_edge_level      (m_edge_level),
        .m_center_column   (m_center_column),
        .m_center_row      (m_center_row),
        .m_frame_last      (m_frame_last),
        .mismatch_count    (mismatch_count),
        .outstanding_edges (outstanding_edges)
    );

    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 88) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (!stall_on) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) begin
                stall_left <= idle_length();
            end
        end
    end

    always @(posedge aclk) begin
        clock_count <= clock_count + 1;
        if (clock_count >= CYCLE_LIMIT) begin
            $display("sobel_edge_threshold_test: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_write <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_pixel(input pixel_t r, input pixel_t g, input pixel_t b);
        int gap;
        gap = gap_on ? idle_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic make_pixel(output pixel_t r, output pixel_t g, output pixel_t b);
        pixel_t v;
        case (texture)
            TEX_NOISE: begin
                r = pixel_t'($urandom_range(0, 255));
                g = pixel_t'($urandom_range(0, 255));
                b = pixel_t'($urandom_range(0, 255));
            end
            TEX_SMOOTH: begin
                level += int'($urandom_range(0, 12)) - 6;
                if (level < 0) level = 0;
                if (level > 247) level = 247;
                r = pixel_t'(level + int'($urandom_range(0, 8)));
                g = pixel_t'(level + int'($urandom_range(0, 8)));
                b = pixel_t'(level + int'($urandom_range(0, 8)));
            end
            default: begin
                v = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                r = v;
                g = v;
                b = ($urandom_range(0, 7) == 0) ? pixel_t'($urandom_range(0, 255)) : v;
            end
        endcase
    endtask

    // hold the sender until every predicted result has left, then let the pipe empty
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding_edges != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure_phase(input int phase);
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;
        logic [CFG_DATA_W-1:0] td;
        int                    pick;
        case (phase)
            0: begin
                wd = 13'd2;
                hd = 13'd4096;
                td = 13'd0;
            end
            1: begin
                wd = 13'h1FFF;
                hd = 13'd1;
                td = 13'd1443;
            end
            2: begin
                wd = 13'd3;
                hd = 13'h1FFF;
                td = 13'h1FFF;
            end
            3: begin
                wd = 13'd1024;
                hd = 13'd0;
                td = 13'd1444;
            end
            default: begin
                case ($urandom_range(0, 15))
                    0: wd = CFG_DATA_W'($urandom_range(0, 2));
                    1: wd = 13'd1024;
                    2: wd = CFG_DATA_W'($urandom_range(1025, 8191));
                    default: wd = CFG_DATA_W'($urandom_range(3, 24));
                endcase
                case ($urandom_range(0, 15))
                    0: hd = CFG_DATA_W'($urandom_range(0, 2));
                    1: hd = 13'd4096;
                    2: hd = CFG_DATA_W'($urandom_range(4097, 8191));
                    default: hd = CFG_DATA_W'($urandom_range(3, 16));
                endcase
                case ($urandom_range(0, 9))
                    0: td = 13'd0;
                    1: td = CFG_DATA_W'($urandom_range(1443, 8191));
                    2, 3, 4, 5: td = CFG_DATA_W'($urandom_range(0, 1443));
                    default: td = CFG_DATA_W'($urandom_range(0, 160));
                endcase
            end
        endcase
        pick = (phase < 4) ? 7 : $urandom_range(1, 7);
        if ((pick & 1) != 0) write_reg(REG_IMAGE_WIDTH, wd);
        if ((pick & 2) != 0) write_reg(REG_IMAGE_HEIGHT, hd);
        if ((pick & 4) != 0) write_reg(REG_EDGE_THRESHOLD, td);
        if ($urandom_range(0, 15) == 0) begin
            write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 8191)));
        end
    endtask

    initial begin
        pixel_t r;
        pixel_t g;
        pixel_t b;
        pixel_t v;
        int     sent;
        int     burst;
        int     phase;

        aresetn   <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_red     <= '0;
        s_green   <= '0;
        s_blue    <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // a spare register index leaves the geometry alone
        write_reg(REG_SPARE, 13'h1FFF);
        gap_on   = 1'b1;
        stall_on <= 1'b1;

        // smallest frame, full-scale step just over and exactly at the threshold
        wait_for_results();
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        write_reg(REG_EDGE_THRESHOLD, 13'd1019);
        for (int row = 0; row < 3; row++) begin
            for (int col = 0; col < 3; col++) begin
                v = (col == 0) ? 8'd255 : 8'd0;
                send_pixel(v, v, v);
            end
        end
        wait_for_results();
        write_reg(REG_EDGE_THRESHOLD, 13'd1020);
        for (int row = 0; row < 3; row++) begin
            for (int col = 0; col < 3; col++) begin
                v = (row == 0) ? 8'd255 : 8'd0;
                send_pixel(v, v, v);
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            wait_for_results();
            configure_phase(phase);
            gap_on   = ($urandom_range(0, 3) != 0);
            stall_on <= ($urandom_range(0, 3) != 0);
            texture  = texture_t'($urandom_range(0, 2));
            level    = $urandom_range(0, 247);
            burst    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(20, 150);
            repeat (burst) begin
                make_pixel(r, g, b);
                send_pixel(r, g, b);
            end
            sent += burst;
            phase++;
        end
        wait_for_results();

        if (mismatch_count == 0 && outstanding_edges == 0) begin
            $display("sobel_edge_threshold_test: PASS");
        end else begin
            $display("sobel_edge_threshold_test: FAIL");
        end
        $finish;
    end

endmodule
